/* hw/rtl/bfbp_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// bfbp_pkg: shared types and constants of the bloom filter build/probe core
// Transfer item layouts, operation and result codes, hash constants.
// ----------------------------------------------------------------------------
package bfbp_pkg;

  // default sizing of the core
  localparam int unsigned MAX_FILTER_BYTES = 4096;
  localparam int unsigned MAX_KEY_BYTES    = 65535;
  localparam int unsigned MAX_PROBES       = 30;

  // hash constants
  localparam logic [31:0] HASH_MUL  = 32'hc6a4a793;
  localparam logic [31:0] HASH_SEED = 32'hbc9f1d34;

  // operation codes
  localparam logic [1:0] OP_CLEAR = 2'd0;
  localparam logic [1:0] OP_ADD   = 2'd1;
  localparam logic [1:0] OP_QUERY = 2'd2;
  localparam logic [1:0] OP_READ  = 2'd3;

  // result kinds
  localparam logic [1:0] KIND_DONE  = 2'd0;
  localparam logic [1:0] KIND_MATCH = 2'd1;
  localparam logic [1:0] KIND_READ  = 2'd2;

  // configuration port
  localparam int unsigned CFG_IDX_W = 1;
  localparam int unsigned CFG_W     = 13;
  localparam int unsigned NP_W      = 5;
  localparam logic [CFG_IDX_W-1:0] CFG_FILTER_BYTES = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_NUM_PROBES   = 1'd1;

  typedef struct packed {
    logic [1:0]  op;
    logic [15:0] key_length;
    logic [31:0] key_word;
    logic [11:0] byte_index;
  } in_item_t;

  typedef struct packed {
    logic [1:0] kind;
    logic       may_match;
    logic [7:0] read_data;
  } out_item_t;

endpackage
`default_nettype wire

/* hw/rtl/bfbp_ram.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// bfbp_ram: generic single-port-write, single-port-read ram
// One write and one read per cycle, read data registered.
// ----------------------------------------------------------------------------
module bfbp_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 4096,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic [AW-1:0]    raddr_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule
`default_nettype wire

/* hw/rtl/bloom_filter_build_and_probe_core.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// bloom_filter_build_and_probe_core: bloom filter with double-hash probing
// Hashes keys chunk by chunk and sets or tests bits of a ram-based array.
// ----------------------------------------------------------------------------
// Usage:
//   Input transfers carry one op each: clear, add chunk, query chunk, read.
//   A key is sent as 32-bit chunks; key_length is taken on its first chunk.
//   Mid-key chunks give no result; each has a hash multiply and a mix step.
//   A final chunk makes three 33-step remainder runs (hash, step, 2^32
//   wrap) on a shared bit-serial divider, then one ram read and one ram
//   write slot per probe; a query stops at the first clear bit. With zero
//   or more than MAX_PROBES probes it gives its result without probing.
//   A read sends its index through the divider only when MAX_FILTER_BYTES
//   is not a power of two. Clear sweeps the ram one byte a cycle.
//   One item is worked on at a time; in_stall_o is high while busy.
//   After reset the ram is cleared by the same sweep with in_stall_o
//   high; config writes are taken at any time.
//   Results sit in an output register; a stalled receiver does not block
//   the next input transfer, only the next result.
// ----------------------------------------------------------------------------
module bloom_filter_build_and_probe_core #(
  parameter int unsigned MAX_FILTER_BYTES = bfbp_pkg::MAX_FILTER_BYTES,
  parameter int unsigned MAX_KEY_BYTES    = bfbp_pkg::MAX_KEY_BYTES,
  parameter int unsigned MAX_PROBES       = bfbp_pkg::MAX_PROBES
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           in_valid_i,
  output logic                                in_stall_o,
  input  wire bfbp_pkg::in_item_t             in_item_i,
  output logic                                out_valid_o,
  input  wire logic                           out_stall_i,
  output bfbp_pkg::out_item_t                 out_item_o,
  input  wire logic                           cfg_we_i,
  input  wire logic [bfbp_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  wire logic [bfbp_pkg::CFG_W-1:0]     cfg_wdata_i
);

  localparam int unsigned ADDR_W = $clog2(MAX_FILTER_BYTES);
  localparam int unsigned AB_W   = $clog2(MAX_FILTER_BYTES + 1);
  localparam int unsigned BITS_W = AB_W + 3;
  localparam int unsigned KEY_W  = $clog2(MAX_KEY_BYTES + 1);
  localparam bit          IS_POW2 = ((MAX_FILTER_BYTES & (MAX_FILTER_BYTES - 1)) == 0);
  localparam int unsigned NP_W   = bfbp_pkg::NP_W;

  // state codes
  localparam logic [3:0] S_INIT_CLR = 4'd0;
  localparam logic [3:0] S_IDLE     = 4'd1;
  localparam logic [3:0] S_CLR      = 4'd2;
  localparam logic [3:0] S_HASH     = 4'd3;
  localparam logic [3:0] S_HMIX     = 4'd4;
  localparam logic [3:0] S_FINAL    = 4'd5;
  localparam logic [3:0] S_DIV      = 4'd6;
  localparam logic [3:0] S_PR_RD    = 4'd7;
  localparam logic [3:0] S_PR_WR    = 4'd8;
  localparam logic [3:0] S_RD_ISSUE = 4'd9;
  localparam logic [3:0] S_RD_WAIT  = 4'd10;
  localparam logic [3:0] S_EMIT     = 4'd11;

  // divider jobs
  localparam logic [1:0] DP_HASH  = 2'd0;
  localparam logic [1:0] DP_DELTA = 2'd1;
  localparam logic [1:0] DP_WRAP  = 2'd2;
  localparam logic [1:0] DP_INDEX = 2'd3;

  localparam logic [5:0]  DIV_LAST = 6'd32;
  localparam logic [32:0] DIV_WRAP = 33'h1_0000_0000;

  // configuration
  logic [bfbp_pkg::CFG_W-1:0] filter_bytes_q;
  logic [NP_W-1:0]            num_probes_q;

  // control and datapath state
  logic [3:0]        state_q, state_d;
  logic [ADDR_W-1:0] clr_cnt_q, clr_cnt_d;
  logic              open_q, open_d;
  logic [KEY_W-1:0]  bl_q, bl_d;
  logic [31:0]       h_q, h_d;
  logic [31:0]       prod_q, prod_d;
  logic              tail_q, tail_d;
  logic [1:0]        op_q, op_d;
  logic [31:0]       word_q, word_d;
  logic [ADDR_W-1:0] ridx_q, ridx_d;
  logic [32:0]       div_dvd_q, div_dvd_d;
  logic [BITS_W-1:0] div_rem_q, div_rem_d;
  logic [5:0]        div_cnt_q, div_cnt_d;
  logic [1:0]        div_phase_q, div_phase_d;
  logic [BITS_W-1:0] pos_q, pos_d;
  logic [BITS_W-1:0] rd_q, rd_d;
  logic [BITS_W-1:0] adj_q, adj_d;
  logic [31:0]       hcur_q, hcur_d;
  logic [NP_W-1:0]   left_q, left_d;
  bfbp_pkg::out_item_t res_q, res_d;
  logic              out_valid_q, out_valid_d;
  bfbp_pkg::out_item_t out_q, out_d;

  // combinational helpers
  logic [31:0]       fb32, ab32, len32, len_sat;
  logic [AB_W-1:0]   arr_bytes;
  logic [BITS_W-1:0] bits_w;
  logic [31:0]       tail_mask, hash_sum, mul_a, mul_p, delta;
  logic [BITS_W-1:0] div_dsr;
  logic [BITS_W:0]   div_trial;
  logic [BITS_W-1:0] div_rem_nx;
  logic [BITS_W:0]   s1, s2;
  logic [BITS_W-1:0] p1, p2, pos_nx;
  logic [32:0]       hcur_sum;
  logic [ADDR_W-1:0] probe_idx;
  logic [7:0]        bit_mask;
  logic              hit, out_free, emit_go, no_probes;
  logic              ram_we;
  logic [ADDR_W-1:0] ram_waddr, ram_raddr;
  logic [7:0]        ram_wdata, ram_rdata;

  // filter size clamped into its legal range
  assign fb32      = 32'(filter_bytes_q);
  assign ab32      = (fb32 < 32'd8) ? 32'd8 :
                     (fb32 > 32'(MAX_FILTER_BYTES)) ? 32'(MAX_FILTER_BYTES) : fb32;
  assign arr_bytes = AB_W'(ab32);
  assign bits_w    = {arr_bytes, 3'b000};

  assign len32   = 32'(in_item_i.key_length);
  assign len_sat = (len32 > 32'(MAX_KEY_BYTES)) ? 32'(MAX_KEY_BYTES) : len32;

  always_comb begin
    tail_mask = 32'hffff_ffff;
    if (bl_q < KEY_W'(4)) begin
      case (bl_q[1:0])
        2'd1:    tail_mask = 32'h0000_00ff;
        2'd2:    tail_mask = 32'h0000_ffff;
        2'd3:    tail_mask = 32'h00ff_ffff;
        default: tail_mask = 32'hffff_ffff;
      endcase
    end
  end

  // one shared multiplier: key length on open, running hash otherwise
  assign hash_sum = h_q + (word_q & tail_mask);
  assign mul_a    = (state_q == S_IDLE) ? len_sat : hash_sum;
  assign mul_p    = 32'(mul_a * bfbp_pkg::HASH_MUL);

  assign delta = {h_q[16:0], h_q[31:17]};

  // bit-serial remainder step
  assign div_dsr    = (div_phase_q == DP_INDEX) ? BITS_W'(MAX_FILTER_BYTES) : bits_w;
  assign div_trial  = {div_rem_q, div_dvd_q[32]};
  assign div_rem_nx = (div_trial >= {1'b0, div_dsr}) ? BITS_W'(div_trial - {1'b0, div_dsr})
                                                     : BITS_W'(div_trial);

  // next probe position mod bits, with a correction when h wraps past 2^32
  assign hcur_sum = {1'b0, hcur_q} + {1'b0, delta};
  assign s1       = {1'b0, pos_q} + {1'b0, rd_q};
  assign p1       = (s1 >= {1'b0, bits_w}) ? BITS_W'(s1 - {1'b0, bits_w}) : BITS_W'(s1);
  assign s2       = {1'b0, p1} + {1'b0, adj_q};
  assign p2       = (s2 >= {1'b0, bits_w}) ? BITS_W'(s2 - {1'b0, bits_w}) : BITS_W'(s2);
  assign pos_nx   = hcur_sum[32] ? p2 : p1;

  assign probe_idx = pos_q[ADDR_W+2:3];
  assign bit_mask  = 8'(8'd1 << pos_q[2:0]);
  assign hit       = |(ram_rdata & bit_mask);
  assign no_probes = (num_probes_q == '0) || (32'(num_probes_q) > 32'(MAX_PROBES));

  assign out_free = !out_valid_q || !out_stall_i;
  assign emit_go  = (state_q == S_EMIT) && out_free;

  assign ram_raddr = (state_q == S_PR_RD) ? probe_idx : ridx_q;

  always_comb begin
    state_d     = state_q;
    clr_cnt_d   = clr_cnt_q;
    open_d      = open_q;
    bl_d        = bl_q;
    h_d         = h_q;
    prod_d      = prod_q;
    tail_d      = tail_q;
    op_d        = op_q;
    word_d      = word_q;
    ridx_d      = ridx_q;
    div_dvd_d   = div_dvd_q;
    div_rem_d   = div_rem_q;
    div_cnt_d   = div_cnt_q;
    div_phase_d = div_phase_q;
    pos_d       = pos_q;
    rd_d        = rd_q;
    adj_d       = adj_q;
    hcur_d      = hcur_q;
    left_d      = left_q;
    res_d       = res_q;
    ram_we      = 1'b0;
    ram_waddr   = clr_cnt_q;
    ram_wdata   = '0;

    case (state_q)
      S_INIT_CLR: begin
        ram_we    = 1'b1;
        clr_cnt_d = clr_cnt_q + 1'b1;
        if (clr_cnt_q == ADDR_W'(MAX_FILTER_BYTES - 1)) begin
          clr_cnt_d = '0;
          state_d   = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid_i) begin
          op_d   = in_item_i.op;
          word_d = in_item_i.key_word;
          case (in_item_i.op)
            bfbp_pkg::OP_CLEAR: begin
              open_d    = 1'b0;
              bl_d      = '0;
              h_d       = '0;
              clr_cnt_d = '0;
              state_d   = S_CLR;
            end
            bfbp_pkg::OP_READ: begin
              if (IS_POW2) begin
                ridx_d  = ADDR_W'(32'(in_item_i.byte_index));
                state_d = S_RD_ISSUE;
              end else begin
                div_dvd_d   = 33'(in_item_i.byte_index);
                div_rem_d   = '0;
                div_cnt_d   = '0;
                div_phase_d = DP_INDEX;
                state_d     = S_DIV;
              end
            end
            default: begin
              if (!open_q) begin
                open_d = 1'b1;
                bl_d   = KEY_W'(len_sat);
                h_d    = bfbp_pkg::HASH_SEED ^ mul_p;
              end
              state_d = S_HASH;
            end
          endcase
        end
      end
      S_CLR: begin
        ram_we    = 1'b1;
        clr_cnt_d = clr_cnt_q + 1'b1;
        if (clr_cnt_q == ADDR_W'(MAX_FILTER_BYTES - 1)) begin
          clr_cnt_d       = '0;
          res_d.kind      = bfbp_pkg::KIND_DONE;
          res_d.may_match = 1'b0;
          res_d.read_data = '0;
          state_d         = S_EMIT;
        end
      end
      S_HASH: begin
        if (bl_q == '0) begin
          // zero-length key goes straight to probing
          state_d = S_FINAL;
        end else begin
          prod_d  = mul_p;
          tail_d  = (bl_q < KEY_W'(4));
          bl_d    = (bl_q < KEY_W'(4)) ? '0 : bl_q - KEY_W'(4);
          state_d = S_HMIX;
        end
      end
      S_HMIX: begin
        h_d     = tail_q ? (prod_q ^ (prod_q >> 24)) : (prod_q ^ (prod_q >> 16));
        state_d = (bl_q != '0) ? S_IDLE : S_FINAL;
      end
      S_FINAL: begin
        open_d = 1'b0;
        if (no_probes) begin
          res_d.kind      = (op_q == bfbp_pkg::OP_ADD) ? bfbp_pkg::KIND_DONE
                                                       : bfbp_pkg::KIND_MATCH;
          res_d.may_match = (op_q != bfbp_pkg::OP_ADD);
          res_d.read_data = '0;
          state_d         = S_EMIT;
        end else begin
          div_dvd_d   = {1'b0, h_q};
          div_rem_d   = '0;
          div_cnt_d   = '0;
          div_phase_d = DP_HASH;
          state_d     = S_DIV;
        end
      end
      S_DIV: begin
        div_dvd_d = {div_dvd_q[31:0], 1'b0};
        div_rem_d = div_rem_nx;
        div_cnt_d = div_cnt_q + 1'b1;
        if (div_cnt_q == DIV_LAST) begin
          div_cnt_d = '0;
          div_rem_d = '0;
          case (div_phase_q)
            DP_HASH: begin
              pos_d       = div_rem_nx;
              div_dvd_d   = {1'b0, delta};
              div_phase_d = DP_DELTA;
            end
            DP_DELTA: begin
              rd_d        = div_rem_nx;
              div_dvd_d   = DIV_WRAP;
              div_phase_d = DP_WRAP;
            end
            DP_WRAP: begin
              // adding bits - (2^32 mod bits) undoes a 32-bit wrap of h
              adj_d   = (div_rem_nx == '0) ? '0 : bits_w - div_rem_nx;
              hcur_d  = h_q;
              left_d  = num_probes_q;
              state_d = S_PR_RD;
            end
            default: begin
              ridx_d  = div_rem_nx[ADDR_W-1:0];
              state_d = S_RD_ISSUE;
            end
          endcase
        end
      end
      S_PR_RD: begin
        state_d = S_PR_WR;
      end
      S_PR_WR: begin
        if (op_q == bfbp_pkg::OP_ADD) begin
          ram_we    = 1'b1;
          ram_waddr = probe_idx;
          ram_wdata = ram_rdata | bit_mask;
        end
        pos_d  = pos_nx;
        hcur_d = hcur_sum[31:0];
        left_d = left_q - 1'b1;
        if ((op_q != bfbp_pkg::OP_ADD) && !hit) begin
          res_d.kind      = bfbp_pkg::KIND_MATCH;
          res_d.may_match = 1'b0;
          res_d.read_data = '0;
          state_d         = S_EMIT;
        end else if (left_q == NP_W'(1)) begin
          res_d.kind      = (op_q == bfbp_pkg::OP_ADD) ? bfbp_pkg::KIND_DONE
                                                       : bfbp_pkg::KIND_MATCH;
          res_d.may_match = (op_q != bfbp_pkg::OP_ADD);
          res_d.read_data = '0;
          state_d         = S_EMIT;
        end else begin
          state_d = S_PR_RD;
        end
      end
      S_RD_ISSUE: begin
        state_d = S_RD_WAIT;
      end
      S_RD_WAIT: begin
        res_d.kind      = bfbp_pkg::KIND_READ;
        res_d.may_match = 1'b0;
        res_d.read_data = ram_rdata;
        state_d         = S_EMIT;
      end
      S_EMIT: begin
        if (out_free) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // output register
  always_comb begin
    out_valid_d = out_valid_q;
    out_d       = out_q;
    if (emit_go) begin
      out_valid_d = 1'b1;
      out_d       = res_q;
    end else if (out_free) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= S_INIT_CLR;
      clr_cnt_q      <= '0;
      open_q         <= 1'b0;
      bl_q           <= '0;
      h_q            <= '0;
      div_cnt_q      <= '0;
      out_valid_q    <= 1'b0;
      filter_bytes_q <= bfbp_pkg::CFG_W'(8);
      num_probes_q   <= NP_W'(1);
    end else begin
      state_q     <= state_d;
      clr_cnt_q   <= clr_cnt_d;
      open_q      <= open_d;
      bl_q        <= bl_d;
      h_q         <= h_d;
      div_cnt_q   <= div_cnt_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        case (cfg_idx_i)
          bfbp_pkg::CFG_FILTER_BYTES: filter_bytes_q <= cfg_wdata_i;
          bfbp_pkg::CFG_NUM_PROBES:   num_probes_q   <= cfg_wdata_i[NP_W-1:0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q      <= prod_d;
    tail_q      <= tail_d;
    op_q        <= op_d;
    word_q      <= word_d;
    ridx_q      <= ridx_d;
    div_dvd_q   <= div_dvd_d;
    div_rem_q   <= div_rem_d;
    div_phase_q <= div_phase_d;
    pos_q       <= pos_d;
    rd_q        <= rd_d;
    adj_q       <= adj_d;
    hcur_q      <= hcur_d;
    left_q      <= left_d;
    res_q       <= res_d;
    out_q       <= out_d;
  end

  bfbp_ram #(
    .WIDTH (8),
    .DEPTH (MAX_FILTER_BYTES)
  ) u_bit_array (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

`ifndef SYNTHESIS
  // ram is written only by a clearing sweep or a probe write-back
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_we |-> (state_q == S_INIT_CLR || state_q == S_CLR || state_q == S_PR_WR))
    else $error("ram write outside clear or probe write");

  // a finished result always reaches the output register once it is free
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    emit_go |=> out_valid_q)
    else $error("result lost on its way to the output register");

  // match flag only on query answers
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_q.kind != bfbp_pkg::KIND_MATCH) |-> !out_q.may_match)
    else $error("match flag set on a non-query result");

  // read data only on read results
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_q.kind != bfbp_pkg::KIND_READ) |-> (out_q.read_data == '0))
    else $error("read data set on a non-read result");

  // a transfer is only taken when no item is in flight
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> (state_q != S_IDLE))
    else $error("accepted item did not start work");
`endif

endmodule
`default_nettype wire
